// ----- hdl/hptw_pkg.sv -----
// ----------------------------------------------------------------------------
// hptw_pkg
// Shared constants, codes and types of the page table walker.
// ----------------------------------------------------------------------------
package hptw_pkg;

	localparam int OFFSET_BITS = 4;
	localparam int LEVELS      = 4;
	localparam int FRAMES      = 64;
	localparam int VADDR_BITS  = 20;

	localparam int PAGE_WORDS  = 1 << OFFSET_BITS;
	localparam int PN_BITS     = VADDR_BITS - OFFSET_BITS;
	localparam int LEVEL_BITS  = PN_BITS / LEVELS;
	localparam int FRAME_BITS  = $clog2(FRAMES);
	localparam int ADDR_BITS   = FRAME_BITS + OFFSET_BITS;
	localparam int DEPTH_BITS  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int MAX_RESULTS = 6;
	localparam int MAX_EVICT   = MAX_RESULTS - 2;
	localparam int NCNT_BITS   = 3;

	typedef enum logic [1:0] {
		KIND_EVICT   = 2'd0,
		KIND_RESTORE = 2'd1,
		KIND_XLATE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_EMPTY  = 2'd0,
		MODE_MAX    = 2'd1,
		MODE_VICT   = 2'd2,
		MODE_UNLINK = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		D_IDLE,
		D_RD,
		D_EVAL,
		D_POST,
		D_NEXT,
		D_NODE,
		D_FIN
	} dfs_state_t;

	typedef enum logic [4:0] {
		W_INIT,
		W_IDLE,
		W_RD,
		W_CHK,
		W_EMPTY_GO,
		W_EMPTY_WT,
		W_MAX_GO,
		W_MAX_WT,
		W_VICT_GO,
		W_VICT_WT,
		W_EVICT,
		W_UNL_GO,
		W_UNL_WT,
		W_ALLOC,
		W_CLR,
		W_LINK,
		W_RESTORE,
		W_XLATE,
		W_FAIL
	} walk_state_t;

	typedef struct packed {
		logic                  rd;
		logic                  wr;
		logic [ADDR_BITS-1:0]  addr;
		logic [FRAME_BITS-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic                  start;
		mode_t                 mode;
		logic [FRAME_BITS-1:0] target;
		logic [PN_BITS-1:0]    pn;
	} dfs_cmd_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic                  found;
		logic [FRAME_BITS-1:0] frame;
		logic [FRAME_BITS-1:0] mx;
		logic                  vvalid;
		logic [FRAME_BITS-1:0] vframe;
		logic [PN_BITS-1:0]    vpage;
	} dfs_rsp_t;

endpackage

// ----- hdl/hierarchical_page_table_walker.sv -----
// ----------------------------------------------------------------------------
// hierarchical_page_table_walker
// Multilevel page table translation with frame allocation, eviction and
// table clearing over a frame-indexed table store.
// ----------------------------------------------------------------------------
// channel  dir  tdata                       tuser     tlast
// s_*      in   vaddr[19:0]                 -         -
// m_*      out  frame, page, phys address   kind      last of access
//
// Each store read is registered before it is checked; a hit walk accepts the
// address, reads and checks one entry per level, then emits its result items.
// A missing entry runs up to four depth-first scans of the tree and, except
// at the last level, a clear of the new table's 16 words.
// After reset a clearing pass zeroes all 1024 store words with s_tready
// low. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
module hierarchical_page_table_walker
	import hptw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // vaddr[19:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // frame[5:0], page[21:6], phys_addr[31:22]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	walk_state_t state_q, state_d;

	logic [FRAME_BITS-1:0]  store [FRAMES*PAGE_WORDS];
	logic [FRAME_BITS-1:0]  rdata_q;

	logic [ADDR_BITS-1:0]   init_q;
	logic [PN_BITS-1:0]     pn_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [DEPTH_BITS-1:0]  lvl_q;
	logic [FRAME_BITS-1:0]  cur_q;
	logic [FRAME_BITS-1:0]  f_q;
	logic [OFFSET_BITS-1:0] ci_q;
	logic [NCNT_BITS-1:0]   n_q;

	logic                   mv_q;
	logic [31:0]            mdata_q;
	kind_t                  muser_q;
	logic                   mlast_q;

	mem_req_t               wreq, dreq, mreq;
	dfs_cmd_t               cmd;
	dfs_rsp_t               rsp;

	logic                   slot_free;
	logic                   emit;
	kind_t                  e_kind;
	logic [FRAME_BITS-1:0]  e_frame;
	logic [PN_BITS-1:0]     e_page;
	logic [ADDR_BITS-1:0]   e_pa;
	logic                   e_last;
	logic [OFFSET_BITS-1:0] idx;
	logic                   top_lvl;

	assign idx       = OFFSET_BITS'(pn_q[(LEVELS-1-lvl_q)*LEVEL_BITS +: LEVEL_BITS]);
	assign top_lvl   = (lvl_q == DEPTH_BITS'(LEVELS - 1));
	assign slot_free = !mv_q || m_tready;

	hptw_dfs u_dfs (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rdata  (rdata_q),
		.req    (dreq),
		.rsp    (rsp)
	);

	assign mreq = rsp.busy ? dreq : wreq;

	always_ff @(posedge clk) begin
		if (mreq.wr) store[mreq.addr] <= mreq.wdata;
		if (mreq.rd) rdata_q <= store[mreq.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		wreq       = '0;
		wreq.addr  = {cur_q, idx};
		cmd        = '0;
		cmd.pn     = pn_q;
		cmd.target = f_q;
		emit       = 1'b0;
		e_kind     = KIND_XLATE;
		e_frame    = cur_q;
		e_page     = pn_q;
		e_pa       = '0;
		e_last     = 1'b0;
		unique case (state_q)
			W_INIT: begin
				wreq.wr   = 1'b1;
				wreq.addr = init_q;
				if (init_q == ADDR_BITS'(FRAMES*PAGE_WORDS - 1)) state_d = W_IDLE;
			end
			W_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = W_RD;
			end
			W_RD: begin
				wreq.rd = 1'b1;
				state_d = W_CHK;
			end
			W_CHK: begin
				if (rdata_q == '0) state_d = W_EMPTY_GO;
				else if (top_lvl) state_d = W_RESTORE;
				else state_d = W_RD;
			end
			W_EMPTY_GO: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_EMPTY;
				state_d   = W_EMPTY_WT;
			end
			W_EMPTY_WT: begin
				if (rsp.done) state_d = rsp.found ? W_UNL_GO : W_MAX_GO;
			end
			W_MAX_GO: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_MAX;
				state_d   = W_MAX_WT;
			end
			W_MAX_WT: begin
				if (rsp.done) begin
					state_d = (rsp.mx != FRAME_BITS'(FRAMES - 1)) ? W_ALLOC : W_VICT_GO;
				end
			end
			W_VICT_GO: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_VICT;
				state_d   = W_VICT_WT;
			end
			W_VICT_WT: begin
				if (rsp.done) state_d = rsp.vvalid ? W_EVICT : W_FAIL;
			end
			W_EVICT: begin
				e_kind  = KIND_EVICT;
				e_frame = f_q;
				e_page  = rsp.vpage;
				if (n_q < NCNT_BITS'(MAX_EVICT)) begin
					emit = 1'b1;
					if (slot_free) state_d = W_UNL_GO;
				end else begin
					state_d = W_UNL_GO;
				end
			end
			W_UNL_GO: begin
				cmd.start = 1'b1;
				cmd.mode  = MODE_UNLINK;
				state_d   = W_UNL_WT;
			end
			W_UNL_WT: begin
				if (rsp.done) state_d = W_ALLOC;
			end
			W_ALLOC: begin
				state_d = top_lvl ? W_LINK : W_CLR;
			end
			W_CLR: begin
				wreq.wr   = 1'b1;
				wreq.addr = {f_q, ci_q};
				if (ci_q == OFFSET_BITS'(PAGE_WORDS - 1)) state_d = W_LINK;
			end
			W_LINK: begin
				wreq.wr    = 1'b1;
				wreq.wdata = f_q;
				state_d    = top_lvl ? W_RESTORE : W_RD;
			end
			W_RESTORE: begin
				emit   = 1'b1;
				e_kind = KIND_RESTORE;
				if (slot_free) state_d = W_XLATE;
			end
			W_XLATE: begin
				emit   = 1'b1;
				e_pa   = {cur_q, off_q};
				e_last = 1'b1;
				if (slot_free) state_d = W_IDLE;
			end
			W_FAIL: begin
				emit    = 1'b1;
				e_frame = '0;
				e_last  = 1'b1;
				if (slot_free) state_d = W_IDLE;
			end
			default: state_d = W_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			mv_q   <= 1'b0;
		end else begin
			if (state_q == W_INIT) init_q <= init_q + ADDR_BITS'(1);
			if (emit && slot_free) mv_q <= 1'b1;
			else if (m_tready) mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			mdata_q <= {e_pa, e_page, e_frame};
			muser_q <= e_kind;
			mlast_q <= e_last;
		end
		case (state_q)
			W_IDLE: begin
				if (s_tvalid) begin
					pn_q  <= s_tdata[VADDR_BITS-1:OFFSET_BITS];
					off_q <= s_tdata[OFFSET_BITS-1:0];
					lvl_q <= '0;
					cur_q <= '0;
					n_q   <= '0;
				end
			end
			W_CHK: begin
				if (rdata_q != '0) begin
					cur_q <= rdata_q;
					if (!top_lvl) lvl_q <= lvl_q + DEPTH_BITS'(1);
				end
			end
			W_EMPTY_WT: begin
				if (rsp.done && rsp.found) f_q <= rsp.frame;
			end
			W_MAX_WT: begin
				if (rsp.done) f_q <= rsp.mx + FRAME_BITS'(1);
			end
			W_VICT_WT: begin
				if (rsp.done) f_q <= rsp.vframe;
			end
			W_EVICT: begin
				if (n_q < NCNT_BITS'(MAX_EVICT) && slot_free) n_q <= n_q + NCNT_BITS'(1);
			end
			W_ALLOC: begin
				ci_q <= '0;
			end
			W_CLR: begin
				ci_q <= ci_q + OFFSET_BITS'(1);
			end
			W_LINK: begin
				cur_q <= f_q;
				if (!top_lvl) lvl_q <= lvl_q + DEPTH_BITS'(1);
			end
			default: ;
		endcase
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;
	assign m_tlast  = mlast_q;

endmodule

// ----- hdl/hptw_dfs.sv -----
// ----------------------------------------------------------------------------
// hptw_dfs
// Depth-first tree traversal engine over the table store, with a bounded
// stack: empty table search, highest frame, victim search and unlink.
// ----------------------------------------------------------------------------
module hptw_dfs
	import hptw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dfs_cmd_t              cmd,
	input  logic [FRAME_BITS-1:0] rdata,
	output mem_req_t              req,
	output dfs_rsp_t              rsp
);

	dfs_state_t state_q, state_d;

	logic [DEPTH_BITS-1:0]  dq_q;
	logic [FRAME_BITS-1:0]  fr_q [LEVELS];
	logic [OFFSET_BITS-1:0] of_q [LEVELS];
	logic                   hs_q [LEVELS];
	logic [FRAME_BITS-1:0]  en_q [LEVELS];

	mode_t                  mode_q;
	logic [FRAME_BITS-1:0]  target_q;
	logic [PN_BITS-1:0]     pn_q;
	logic                   found_q;
	logic [FRAME_BITS-1:0]  frame_q;
	logic [FRAME_BITS-1:0]  mx_q;
	logic [PN_BITS:0]       best_q;
	logic                   vvalid_q;
	logic [FRAME_BITS-1:0]  vframe_q;
	logic [PN_BITS-1:0]     vpage_q;

	logic [DEPTH_BITS-1:0]  dq_up;
	logic [PN_BITS-1:0]     value;
	logic [PN_BITS-1:0]     diff;
	logic [PN_BITS:0]       wrap;
	logic [PN_BITS:0]       cyc_dist;
	logic                   path_match;
	logic                   at_leaf;
	logic                   last_off;

	assign dq_up    = dq_q + DEPTH_BITS'(1);
	assign at_leaf  = (dq_q == DEPTH_BITS'(LEVELS - 1));
	assign last_off = (of_q[dq_q] == OFFSET_BITS'(PAGE_WORDS - 1));

	always_comb begin
		value = '0;
		for (int l = 0; l < LEVELS; l++) begin
			value = PN_BITS'({value, of_q[l][LEVEL_BITS-1:0]});
		end
	end

	always_comb begin
		diff     = (pn_q > value) ? (pn_q - value) : (value - pn_q);
		wrap     = {1'b1, {PN_BITS{1'b0}}} - {1'b0, diff};
		cyc_dist = (wrap < {1'b0, diff}) ? wrap : {1'b0, diff};
	end

	always_comb begin
		path_match = 1'b1;
		for (int l = 0; l < LEVELS; l++) begin
			if (l < int'(dq_q) &&
			    of_q[l][LEVEL_BITS-1:0] != pn_q[(LEVELS-1-l)*LEVEL_BITS +: LEVEL_BITS]) begin
				path_match = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req       = '0;
		req.addr  = {fr_q[dq_q], of_q[dq_q]};
		unique case (state_q)
			D_IDLE: begin
				if (cmd.start) state_d = D_RD;
			end
			D_RD: begin
				req.rd  = 1'b1;
				state_d = D_EVAL;
			end
			D_EVAL: begin
				if (rdata == '0) state_d = D_NEXT;
				else if (!at_leaf) state_d = D_RD;
				else state_d = D_POST;
			end
			D_POST: begin
				req.wr  = (mode_q == MODE_UNLINK) && (en_q[dq_q] == target_q);
				state_d = D_NEXT;
			end
			D_NEXT: begin
				state_d = last_off ? D_NODE : D_RD;
			end
			D_NODE: begin
				if ((mode_q == MODE_EMPTY && !hs_q[dq_q] && !path_match) || dq_q == '0) begin
					state_d = D_FIN;
				end else begin
					state_d = D_POST;
				end
			end
			D_FIN: begin
				state_d = D_IDLE;
			end
			default: state_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (cmd.start) begin
					mode_q   <= cmd.mode;
					target_q <= cmd.target;
					pn_q     <= cmd.pn;
					dq_q     <= '0;
					fr_q[0]  <= '0;
					of_q[0]  <= '0;
					hs_q[0]  <= 1'b0;
					found_q  <= 1'b0;
					mx_q     <= '0;
					best_q   <= '0;
					vvalid_q <= 1'b0;
				end
			end
			D_EVAL: begin
				en_q[dq_q] <= rdata;
				if (rdata != '0) begin
					hs_q[dq_q] <= 1'b1;
					if (mode_q == MODE_MAX && rdata > mx_q) mx_q <= rdata;
					if (!at_leaf) begin
						dq_q        <= dq_up;
						fr_q[dq_up] <= rdata;
						of_q[dq_up] <= '0;
						hs_q[dq_up] <= 1'b0;
					end else if (mode_q == MODE_VICT && cyc_dist > best_q) begin
						best_q   <= cyc_dist;
						vpage_q  <= value;
						vframe_q <= rdata;
						vvalid_q <= 1'b1;
					end
				end
			end
			D_NEXT: begin
				if (!last_off) of_q[dq_q] <= of_q[dq_q] + OFFSET_BITS'(1);
			end
			D_NODE: begin
				if (mode_q == MODE_EMPTY && !hs_q[dq_q] && !path_match) begin
					found_q <= 1'b1;
					frame_q <= fr_q[dq_q];
				end else if (dq_q != '0) begin
					dq_q <= dq_q - DEPTH_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp.busy   = (state_q != D_IDLE);
		rsp.done   = (state_q == D_FIN);
		rsp.found  = found_q;
		rsp.frame  = frame_q;
		rsp.mx     = mx_q;
		rsp.vvalid = vvalid_q;
		rsp.vframe = vframe_q;
		rsp.vpage  = vpage_q;
	end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page table walker: a directed table of
// addresses followed by random ones, all predicted by a behavioral copy of
// the walk and compared item by item, with random stalls on both sides except in a final stall-free run.
// ----------------------------------------------------------------------------
module tb
	import hptw_pkg::*;
;

	typedef struct {
		kind_t       kind;
		logic [5:0]  frame;
		logic [15:0] page;
		logic [9:0]  pa;
		logic        last;
	} access_result_t;

	typedef struct {
		logic [19:0] va;
		bit          typed;
		logic [5:0]  frame;
		logic [9:0]  pa;
	} addr_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	logic [5:0]     page_tables [0:1023];
	access_result_t pending_results [$];
	int             errors = 0;
	bit             quiet = 0;
	int             far_dist;
	int             far_page;
	int             far_frame;

	hierarchical_page_table_walker DUT (.*);

	always #5 clk = ~clk;

	function automatic int tbl_rd(int frame, int off);
		return page_tables[frame * 16 + off];
	endfunction

	function automatic int empty_table(int frame, int depth, int path, int pn);
		bit linked;
		int e;
		int r;
		linked = 0;
		if (depth >= LEVELS) return -1;
		for (int off = 0; off < PAGE_WORDS; off++) begin
			e = tbl_rd(frame, off);
			if (e != 0) begin
				linked = 1;
				r = empty_table(e, depth + 1, (path << LEVEL_BITS) + off, pn);
				if (r != -1) return r;
			end
		end
		if (path == (pn >> (LEVEL_BITS * (LEVELS - depth)))) return -1;
		return linked ? -1 : frame;
	endfunction

	function automatic int highest_frame(int frame, int depth);
		int mx;
		int e;
		int m;
		mx = frame;
		if (depth >= LEVELS) return mx;
		for (int off = 0; off < PAGE_WORDS; off++) begin
			e = tbl_rd(frame, off);
			if (e != 0) begin
				m = highest_frame(e, depth + 1);
				if (m > mx) mx = m;
			end
		end
		return mx;
	endfunction

	function automatic void farthest_page(int frame, int depth, int value, int pn);
		int d;
		int cyc_dist;
		int e;
		if (depth >= LEVELS) begin
			d = (pn > value) ? pn - value : value - pn;
			cyc_dist = ((65536 - d) < d) ? 65536 - d : d;
			if (cyc_dist > far_dist) begin
				far_dist = cyc_dist;
				far_page = value;
				far_frame = frame;
			end
			return;
		end
		for (int off = 0; off < PAGE_WORDS; off++) begin
			e = tbl_rd(frame, off);
			if (e != 0) farthest_page(e, depth + 1, (value << LEVEL_BITS) + off, pn);
		end
	endfunction

	function automatic void unlink_table(int target, int frame, int depth);
		int e;
		if (depth >= LEVELS) return;
		for (int off = 0; off < PAGE_WORDS; off++) begin
			e = tbl_rd(frame, off);
			if (e != 0) begin
				unlink_table(target, e, depth + 1);
				if (e == target) page_tables[frame * 16 + off] = 0;
			end
		end
	endfunction

	function automatic void push_result(kind_t k, int frame, int page, int pa, bit last);
		access_result_t r;
		r.kind = k;
		r.frame = frame[5:0];
		r.page = page[15:0];
		r.pa = pa[9:0];
		r.last = last;
		pending_results.push_back(r);
	endfunction

	function automatic void walk_table(logic [19:0] va);
		int off;
		int pn;
		int cur;
		int idx;
		int e;
		int f;
		int mx;
		int evicted;
		off = va[3:0];
		pn = va[19:4];
		cur = 0;
		evicted = 0;
		for (int d = 0; d < LEVELS; d++) begin
			idx = (pn >> (PN_BITS - (d + 1) * LEVEL_BITS)) & (PAGE_WORDS - 1);
			e = tbl_rd(cur, idx);
			if (e == 0) begin
				f = empty_table(0, 0, 0, pn);
				if (f != -1) begin
					unlink_table(f, 0, 0);
				end else begin
					mx = highest_frame(0, 0);
					if (mx + 1 < FRAMES) begin
						f = mx + 1;
					end else begin
						far_dist = 0;
						far_page = 0;
						far_frame = -1;
						farthest_page(0, 0, 0, pn);
						if (far_frame == -1) begin
							push_result(KIND_XLATE, 0, pn, 0, 1);
							return;
						end
						if (evicted < MAX_EVICT) begin
							push_result(KIND_EVICT, far_frame, far_page, 0, 0);
							evicted++;
						end
						unlink_table(far_frame, 0, 0);
						f = far_frame;
					end
				end
				if (d + 1 < LEVELS)
					for (int i = 0; i < PAGE_WORDS; i++) page_tables[f * 16 + i] = 0;
				page_tables[cur * 16 + idx] = f[5:0];
				e = f;
			end
			cur = e;
		end
		push_result(KIND_RESTORE, cur, pn, 0, 0);
		push_result(KIND_XLATE, cur, pn, cur * PAGE_WORDS + off, 1);
	endfunction

	task automatic send_address(logic [19:0] va);
		if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
		@(negedge clk);
		s_tvalid = 1;
		s_tdata = {4'b0, va};
		do @(posedge clk); while (!s_tready);
		walk_table(va);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	always @(negedge clk) begin
		if (quiet) begin
			m_tready = 1;
		end else if ($urandom_range(0, 7) == 0) begin
			m_tready = 0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
			m_tready = 1;
		end else begin
			m_tready = 1;
		end
	end

	always @(posedge clk) begin
		access_result_t x;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected item: tuser=%0d tdata=%h", m_tuser, m_tdata);
				errors++;
			end else begin
				x = pending_results.pop_front();
				if (m_tuser != x.kind) begin
					$error("kind: expected %0d, got %0d", x.kind, m_tuser);
					errors++;
				end
				if (m_tdata[5:0] != x.frame) begin
					$error("frame: expected %0d, got %0d", x.frame, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[21:6] != x.page) begin
					$error("page: expected %h, got %h", x.page, m_tdata[21:6]);
					errors++;
				end
				if (m_tdata[31:22] != x.pa) begin
					$error("phys_addr: expected %0d, got %0d", x.pa, m_tdata[31:22]);
					errors++;
				end
				if (m_tlast != x.last) begin
					$error("last: expected %0d, got %0d", x.last, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#1s;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		addr_row_t rows [18] = '{
			'{20'h00005, 1, 6'd4, 10'd69},
			'{20'h0000F, 1, 6'd4, 10'd79},
			'{20'hFFFFF, 1, 6'd8, 10'd143},
			'{20'h00000, 1, 6'd4, 10'd64},
			'{20'hFFFF0, 0, 0, 0},
			'{20'h80000, 0, 0, 0},
			'{20'h7FFF3, 0, 0, 0},
			'{20'h12345, 0, 0, 0},
			'{20'h12340, 0, 0, 0},
			'{20'h00010, 0, 0, 0},
			'{20'hF0000, 0, 0, 0},
			'{20'h0F000, 0, 0, 0},
			'{20'h00F00, 0, 0, 0},
			'{20'h000F0, 0, 0, 0},
			'{20'hAAAAA, 0, 0, 0},
			'{20'h55555, 0, 0, 0},
			'{20'h3C3C3, 0, 0, 0},
			'{20'hC3C3C, 0, 0, 0}
		};
		logic [15:0] hot_pages [8];
		logic [19:0] va;
		for (int i = 0; i < 1024; i++) page_tables[i] = 0;
		foreach (hot_pages[i]) hot_pages[i] = $urandom_range(0, 65535);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i]) begin
			send_address(rows[i].va);
			if (rows[i].typed) begin
				if (pending_results[$].frame != rows[i].frame) begin
					$error("row %0d frame: expected %0d, got %0d", i,
						rows[i].frame, pending_results[$].frame);
					errors++;
				end
				if (pending_results[$].pa != rows[i].pa) begin
					$error("row %0d phys_addr: expected %0d, got %0d", i,
						rows[i].pa, pending_results[$].pa);
					errors++;
				end
			end
		end

		while (pending_results.size() != 0) @(posedge clk);

		for (int n = 0; n < 112; n++) begin
			if (n == 90) quiet = 1;
			case ($urandom_range(0, 3))
				0, 1: va = {hot_pages[$urandom_range(0, 7)], 4'($urandom_range(0, 15))};
				default: va = 20'($urandom_range(0, 20'hFFFFF));
			endcase
			send_address(va);
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
